FILE: hdl/cpba_pkg.sv
// ----------------------------------------------------------------------------
// cpba_pkg
// Shared types, codes and bit-search helpers of the first-fit page allocator.
// ----------------------------------------------------------------------------
package cpba_pkg;

    localparam int MAX_PAGES_DEF  = 1024;
    localparam int PAGE_BYTES_DEF = 4096;

    localparam int CNT_W    = 11;   // page counts and pool size
    localparam int ADDR_W   = 32;   // byte addresses
    localparam int WORD_W   = 32;   // bitmap word, one bit per page
    localparam int BIT_W    = 5;    // bit index within a word
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 32;   // widest configuration register

    localparam logic [CNT_W-1:0] POOL_COUNT_RST = 11'd1024;

    typedef enum logic {
        CFG_POOL_BASE  = 1'b0,
        CFG_POOL_COUNT = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_IGNORED = 2'd2,
        ST_RANGE   = 2'd3
    } t_status;

    // Outcome of examining one bitmap word during the first-fit scan
    typedef struct packed {
        logic             found;    // a window of the requested length starts here
        logic             carried;  // window began in earlier words
        logic [BIT_W-1:0] bit_idx;  // window start within this word
        logic [CNT_W-1:0] run_out;  // free run reaching the top of this word
    } t_scan_res;

    // Number of ones from bit 0 upward
    function automatic logic [5:0] f_trail_ones(input logic [WORD_W-1:0] v);
        logic [5:0] c;
        c = 6'd32;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!v[i]) c = 6'(i);
        end
        return c;
    endfunction

    // Number of ones from bit 31 downward
    function automatic logic [5:0] f_lead_ones(input logic [WORD_W-1:0] v);
        logic [5:0] c;
        c = 6'd32;
        for (int i = 0; i < WORD_W; i++) begin
            if (!v[i]) c = 6'(WORD_W - 1 - i);
        end
        return c;
    endfunction

    // Index of the lowest set bit, 0 when none is set
    function automatic logic [BIT_W-1:0] f_lowest_set(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) idx = BIT_W'(i);
        end
        return idx;
    endfunction

endpackage

FILE: hdl/cpba_ram.sv
// ----------------------------------------------------------------------------
// cpba_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cpba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/cpba_div.sv
// ----------------------------------------------------------------------------
// cpba_div
// Page number of a byte address. The page size is a power of two, so the
// quotient is a right shift, registered and ready in the cycle after start.
// ----------------------------------------------------------------------------
module cpba_div
    import cpba_pkg::*;
#(
    parameter int DIVISOR = PAGE_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ADDR_W-1:0] i_dividend,
    output logic              o_done,
    output logic [ADDR_W-1:0] o_quotient
);

    localparam int SHIFT = $clog2(DIVISOR);

    logic              r_done;
    logic [ADDR_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
            r_q    <= '0;
        end else begin
            r_done <= i_start;
            if (i_start) begin
                r_q <= i_dividend >> SHIFT;
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

FILE: hdl/cpba_scan.sv
// ----------------------------------------------------------------------------
// cpba_scan
// Word evaluator of the first-fit scan: finds the lowest window of free
// pages in one bitmap word, continuing a run carried from lower words.
// ----------------------------------------------------------------------------
module cpba_scan
    import cpba_pkg::*;
#(
    parameter int MAX_PAGES = MAX_PAGES_DEF,
    localparam int NW  = (MAX_PAGES + WORD_W - 1) / WORD_W,
    localparam int WAW = (NW > 1) ? $clog2(NW) : 1,
    localparam int PW  = WAW + BIT_W,
    localparam int XW  = ((PW > CNT_W) ? PW : CNT_W) + 1
) (
    input  logic [WORD_W-1:0] i_word,      // used bits of this word
    input  logic [WAW-1:0]    i_word_idx,
    input  logic [CNT_W-1:0]  i_run_in,
    input  logic [CNT_W-1:0]  i_count,
    input  logic [CNT_W-1:0]  i_pool,      // effective pool size in pages
    output t_scan_res         o_res
);

    logic [XW-1:0]     w_pg0;
    logic [XW-1:0]     w_lim;
    logic [WORD_W-1:0] w_valid;
    logic [WORD_W-1:0] w_free;
    logic [5:0]        w_trail;
    logic [5:0]        w_lead;
    logic [CNT_W:0]    w_reach;
    logic              w_carry_fit;
    logic [5:0]        w_cnt6;
    logic              w_small;
    logic [WORD_W-1:0] w_p [6];
    logic [WORD_W-1:0] w_win;

    assign w_pg0 = XW'({i_word_idx, {BIT_W{1'b0}}});
    assign w_lim = XW'(i_pool) - w_pg0;

    // pages at or beyond the pool size count as used
    always_comb begin
        if (w_pg0 >= XW'(i_pool)) begin
            w_valid = '0;
        end else if (w_lim >= XW'(WORD_W)) begin
            w_valid = '1;
        end else begin
            w_valid = {WORD_W{1'b1}} >> (6'd32 - w_lim[5:0]);
        end
    end

    assign w_free  = ~i_word & w_valid;
    assign w_trail = f_trail_ones(w_free);
    assign w_lead  = f_lead_ones(w_free);

    assign w_reach     = {1'b0, i_run_in} + (CNT_W + 1)'(w_trail);
    assign w_carry_fit = (w_reach >= {1'b0, i_count});

    assign w_cnt6  = i_count[5:0];
    assign w_small = (i_count <= CNT_W'(WORD_W));

    // w_p[k]: bit j set when pages j .. j+2^k-1 of this word are all free
    always_comb begin
        w_p[0] = w_free;
        for (int k = 1; k < 6; k++) begin
            w_p[k] = w_p[k-1] & (w_p[k-1] >> (1 << (k - 1)));
        end
    end

    // compose a window of the requested length from power-of-two pieces
    always_comb begin
        w_win = '1;
        for (int k = 0; k < 6; k++) begin
            if (w_cnt6[k]) begin
                w_win = w_win & (w_p[k] >> (w_cnt6 & 6'((1 << k) - 1)));
            end
        end
        if (!w_small) begin
            w_win = '0;
        end
    end

    always_comb begin
        o_res.found   = w_carry_fit || (|w_win);
        o_res.carried = w_carry_fit;
        o_res.bit_idx = f_lowest_set(w_win);
        if (w_trail == 6'd32) begin
            o_res.run_out = i_run_in + CNT_W'(WORD_W);
        end else begin
            o_res.run_out = CNT_W'(w_lead);
        end
    end

endmodule

FILE: hdl/contiguous_page_bitmap_allocator_top.sv
// ----------------------------------------------------------------------------
// contiguous_page_bitmap_allocator_top
// First-fit page allocator over a bitmap of used pages, held in RAM words.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  s_axis    in         i_s_axis_tvalid/o_tready   tuser op, tdata count, address
//  m_axis    out        o_m_axis_tvalid/i_tready   tuser status, tdata address
//  cfg       in         i_cfg_we                   i_cfg_idx, i_cfg_wdata
//
//  Allocate: one RAM read per scanned bitmap word, from word 0 up to at most
//  ceil(pool/32) words, then a read and a write for each word marked.
//  Free: shifts the address, then the base, to a page number, then makes a
//  range check; out of range it ends there, else each word is read and cleared.
//  Zero counts, null frees and oversize allocations go straight to the result.
//  After reset the bitmap is cleared one word a cycle, ceil(MAX_PAGES/32)
//  words, with o_s_axis_tready low. A held result does not block the next
//  transaction; completion waits only if the output register is still full.
// ----------------------------------------------------------------------------
module contiguous_page_bitmap_allocator_top
    import cpba_pkg::*;
#(
    parameter int MAX_PAGES  = MAX_PAGES_DEF,
    parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [47:0]       i_s_axis_tdata,   // page_count[10:0], free_address[42:11]
    input  logic              i_s_axis_tuser,   // op
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [31:0]       o_m_axis_tdata,   // granted_address[31:0]
    output logic [1:0]        o_m_axis_tuser,   // status[1:0]
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_wdata
);

    localparam int NW  = (MAX_PAGES + WORD_W - 1) / WORD_W;
    localparam int WAW = (NW > 1) ? $clog2(NW) : 1;
    localparam int PW  = WAW + BIT_W;
    localparam int XW  = ((PW > CNT_W) ? PW : CNT_W) + 1;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_SCAN0,
        S_SCAN,
        S_DIVA,
        S_DIVB,
        S_CHK,
        S_RD,
        S_WR,
        S_FIN
    } t_state;

    t_state            r_state;
    logic [ADDR_W-1:0] r_base;
    logic [CNT_W-1:0]  r_ppc;
    t_op               r_op;
    logic [CNT_W-1:0]  r_cnt;
    logic [ADDR_W-1:0] r_addr;
    logic [WAW-1:0]    r_word;
    logic [CNT_W-1:0]  r_run;
    logic [PW-1:0]     r_start;
    logic [PW-1:0]     r_end;
    logic [ADDR_W-1:0] r_pa;
    logic [ADDR_W-1:0] r_pb;
    logic [ADDR_W-1:0] r_offs;
    logic              r_grant;
    t_status           r_status;
    logic              r_dstart;
    logic              r_ovalid;
    logic [ADDR_W-1:0] r_odata;
    t_status           r_ouser;

    logic [CNT_W-1:0]  w_pool;
    logic              w_accept;
    t_op               w_in_op;
    logic [CNT_W-1:0]  w_in_cnt;
    logic [ADDR_W-1:0] w_in_addr;
    logic [XW-1:0]     w_last_pg;
    logic [WAW-1:0]    w_last_word;

    logic              w_ram_we;
    logic [WAW-1:0]    w_ram_waddr;
    logic [WORD_W-1:0] w_ram_wdata;
    logic [WAW-1:0]    w_ram_raddr;
    logic [WORD_W-1:0] w_ram_rdata;

    t_scan_res         w_scan;
    logic [PW-1:0]     w_pg0;
    logic [PW-1:0]     w_fit_start;
    logic [PW-1:0]     w_fit_end;

    logic              w_div_done;
    logic [ADDR_W-1:0] w_div_q;
    logic [ADDR_W-1:0] w_div_in;
    logic              w_div_go;

    logic [ADDR_W-1:0] w_fidx;
    logic              w_frange;
    logic [PW-1:0]     w_fstart;
    logic [PW-1:0]     w_fend;

    logic [BIT_W-1:0]  w_lo;
    logic [BIT_W-1:0]  w_hi;
    logic [WORD_W-1:0] w_mask;
    logic              w_out_free;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_ppc  <= POOL_COUNT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_POOL_BASE:  r_base <= i_cfg_wdata[ADDR_W-1:0];
                CFG_POOL_COUNT: r_ppc  <= i_cfg_wdata[CNT_W-1:0];
                default:        r_base <= r_base;
            endcase
        end
    end

    assign w_pool = (32'(r_ppc) > 32'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : r_ppc;

    assign w_in_op   = t_op'(i_s_axis_tuser);
    assign w_in_cnt  = i_s_axis_tdata[10:0];
    assign w_in_addr = i_s_axis_tdata[42:11];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_last_pg   = XW'(w_pool) - XW'(1);
    assign w_last_word = w_last_pg[PW-1:BIT_W];

    // ------------------------------------------------------------------------
    // Bitmap memory
    // ------------------------------------------------------------------------
    cpba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    always_comb begin
        case (r_state)
            S_SCAN0: w_ram_raddr = '0;
            S_SCAN:  w_ram_raddr = WAW'(r_word + 1'b1);
            default: w_ram_raddr = r_word;
        endcase
    end

    // range of bits of the current word touched by a mark or clear
    assign w_lo   = (r_word == r_start[PW-1:BIT_W]) ? r_start[BIT_W-1:0] : '0;
    assign w_hi   = (r_word == r_end[PW-1:BIT_W]) ? r_end[BIT_W-1:0] : '1;
    assign w_mask = ({WORD_W{1'b1}} << w_lo) & ({WORD_W{1'b1}} >> (5'd31 - w_hi));

    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_waddr = r_word;
        w_ram_wdata = '0;
        case (r_state)
            S_CLR: begin
                w_ram_we = 1'b1;
            end
            S_WR: begin
                w_ram_we    = 1'b1;
                w_ram_wdata = (r_op == OP_ALLOC) ? (w_ram_rdata | w_mask)
                                                 : (w_ram_rdata & ~w_mask);
            end
            default: begin
                w_ram_we = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Scan word evaluator
    // ------------------------------------------------------------------------
    cpba_scan #(
        .MAX_PAGES (MAX_PAGES)
    ) u_scan (
        .i_word     (w_ram_rdata),
        .i_word_idx (r_word),
        .i_run_in   (r_run),
        .i_count    (r_cnt),
        .i_pool     (w_pool),
        .o_res      (w_scan)
    );

    assign w_pg0       = {r_word, {BIT_W{1'b0}}};
    assign w_fit_start = w_scan.carried ? (w_pg0 - PW'(r_run))
                                        : (w_pg0 + PW'(w_scan.bit_idx));
    assign w_fit_end   = w_fit_start + PW'(r_cnt) - PW'(1);

    // ------------------------------------------------------------------------
    // Page number of a byte address
    // ------------------------------------------------------------------------
    assign w_div_in = (r_state == S_DIVB) ? r_base : r_addr;

    // start on a valid free transaction, then again for the pool base
    assign w_div_go = (r_state == S_DIVA) ? w_div_done
                    : (w_accept && w_in_op == OP_FREE && w_in_cnt != '0 && w_in_addr != '0);

    cpba_div #(
        .DIVISOR (PAGE_BYTES)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_dstart),
        .i_dividend (w_div_in),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    assign w_fidx   = r_pa - r_pb;
    assign w_frange = (r_pa < r_pb) || (w_fidx >= 32'(w_pool))
                   || (32'(r_cnt) > (32'(w_pool) - w_fidx));
    assign w_fstart = PW'(w_fidx);
    assign w_fend   = PW'(w_fidx + 32'(r_cnt) - 32'd1);

    assign w_out_free = !r_ovalid || i_m_axis_tready;

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_word   <= '0;
            r_dstart <= 1'b0;
            r_ovalid <= 1'b0;
            r_grant  <= 1'b0;
        end else begin
            r_dstart <= w_div_go;
            if (r_state == S_FIN && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    if (r_word == WAW'(NW - 1)) begin
                        r_word  <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_word <= WAW'(r_word + 1'b1);
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_op    <= w_in_op;
                        r_cnt   <= w_in_cnt;
                        r_addr  <= w_in_addr;
                        r_grant <= 1'b0;
                        if (w_in_cnt == '0 || (w_in_op == OP_FREE && w_in_addr == '0)) begin
                            r_status <= ST_IGNORED;
                            r_state  <= S_FIN;
                        end else if (w_in_op == OP_ALLOC) begin
                            if (w_in_cnt > w_pool) begin
                                r_status <= ST_NOSPACE;
                                r_state  <= S_FIN;
                            end else begin
                                r_state <= S_SCAN0;
                            end
                        end else begin
                            r_state <= S_DIVA;
                        end
                    end
                end
                S_SCAN0: begin
                    r_word  <= '0;
                    r_run   <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (w_scan.found) begin
                        r_start <= w_fit_start;
                        r_end   <= w_fit_end;
                        r_word  <= w_fit_start[PW-1:BIT_W];
                        r_grant <= 1'b1;
                        r_state <= S_RD;
                    end else if (r_word == w_last_word) begin
                        r_status <= ST_NOSPACE;
                        r_state  <= S_FIN;
                    end else begin
                        r_word <= WAW'(r_word + 1'b1);
                        r_run  <= w_scan.run_out;
                    end
                end
                S_DIVA: begin
                    if (w_div_done) begin
                        r_pa    <= w_div_q;
                        r_state <= S_DIVB;
                    end
                end
                S_DIVB: begin
                    if (w_div_done) begin
                        r_pb    <= w_div_q;
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (w_frange) begin
                        r_status <= ST_RANGE;
                        r_state  <= S_FIN;
                    end else begin
                        r_start <= w_fstart;
                        r_end   <= w_fend;
                        r_word  <= w_fstart[PW-1:BIT_W];
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_offs  <= ADDR_W'(r_start * PAGE_BYTES);
                    r_state <= S_WR;
                end
                S_WR: begin
                    if (r_word == r_end[PW-1:BIT_W]) begin
                        r_status <= ST_DONE;
                        r_state  <= S_FIN;
                    end else begin
                        r_word  <= WAW'(r_word + 1'b1);
                        r_state <= S_RD;
                    end
                end
                S_FIN: begin
                    // hold the result until the output register is free
                    if (w_out_free) begin
                        r_ouser  <= r_status;
                        r_odata  <= r_grant ? (r_base + r_offs) : '0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the first-fit page allocator: a table of directed allocate and free
// transactions with pool set-ups, then random phases of varied pool bases
// and sizes, each result compared with a typed row or a bitmap predictor.
// ----------------------------------------------------------------------------
module testbench;
    import cpba_pkg::*;

    localparam int PAGES          = MAX_PAGES_DEF;
    localparam int PAGE_SHIFT     = $clog2(PAGE_BYTES_DEF);
    localparam int RANDOM_ITEMS   = 105;    // per random phase
    localparam int RANDOM_PHASES  = 5;
    localparam int IDLE_LIMIT     = 2000;   // cycles with no transaction
    localparam int TAIL_CYCLES    = 200;
    localparam int PRINT_CAP      = 40;
    localparam int N_DIR          = 29;

    typedef enum logic {
        ROW_ITEM = 1'b0,
        ROW_CFG  = 1'b1
    } t_row_kind;

    // For configuration rows, addr carries the register value
    typedef struct packed {
        t_row_kind         kind;
        t_op               op;
        logic [CNT_W-1:0]  pages;
        logic [ADDR_W-1:0] addr;
        t_cfg_idx          reg_idx;
        logic              typed;
        t_status           status;
        logic [ADDR_W-1:0] granted;
    } t_dir_row;

    typedef struct {
        t_status           status;
        logic [ADDR_W-1:0] granted;
    } t_grant;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  pages;
    } t_run;

    localparam t_dir_row DIRECTED_ROWS [N_DIR] = '{
        '{ROW_ITEM, OP_ALLOC, 11'd0,    32'hFFFF_FFFF, CFG_POOL_BASE,  1'b1, ST_IGNORED, 32'h0},
        '{ROW_ITEM, OP_FREE,  11'd0,    32'h0000_1000, CFG_POOL_BASE,  1'b1, ST_IGNORED, 32'h0},
        '{ROW_ITEM, OP_FREE,  11'd1,    32'h0000_0000, CFG_POOL_BASE,  1'b1, ST_IGNORED, 32'h0},
        '{ROW_ITEM, OP_ALLOC, 11'd2047, 32'h0000_0000, CFG_POOL_BASE,  1'b1, ST_NOSPACE, 32'h0},
        '{ROW_ITEM, OP_ALLOC, 11'd1,    32'h0000_0000, CFG_POOL_BASE,  1'b1, ST_DONE,    32'h0},
        '{ROW_ITEM, OP_ALLOC, 11'd3,    32'h0000_0000, CFG_POOL_BASE,  1'b1, ST_DONE,    32'h1000},
        '{ROW_ITEM, OP_FREE,  11'd1,    32'h0000_1FFF, CFG_POOL_BASE,  1'b0, ST_DONE,    32'h0},
        '{ROW_ITEM, OP_ALLOC, 11'd1,    32'h0000_0000, CFG_POOL_BASE,  1'b0, ST_DONE,    32'h0},
        '{ROW_ITEM, OP_FREE,  11'd1,    32'hFFFF_FFFF, CFG_POOL_BASE,  1'b1, ST_RANGE,   32'h0},
        '{ROW_ITEM, OP_FREE,  11'd2,    32'h003F_F000, CFG_POOL_BASE,  1'b1, ST_RANGE,   32'h0},
        '{ROW_ITEM, OP_FREE,  11'd1024, 32'h0000_0800, CFG_POOL_BASE,  1'b0, ST_DONE,    32'h0},
        '{ROW_ITEM, OP_ALLOC, 11'd1024, 32'h0000_0000, CFG_POOL_BASE,  1'b1, ST_DONE,    32'h0},
        '{ROW_ITEM, OP_ALLOC, 11'd1,    32'h0000_0000, CFG_POOL_BASE,  1'b1, ST_NOSPACE, 32'h0},
        '{ROW_ITEM, OP_FREE,  11'd1024, 32'h0000_0800, CFG_POOL_BASE,  1'b1, ST_DONE,    32'h0},
        '{ROW_CFG,  OP_ALLOC, 11'd0,    32'hFFFF_F000, CFG_POOL_BASE,  1'b0, ST_DONE,    32'h0},
        '{ROW_CFG,  OP_ALLOC, 11'd0,    32'd8,         CFG_POOL_COUNT, 1'b0, ST_DONE,    32'h0},
        '{ROW_ITEM, OP_ALLOC, 11'd2,    32'h0000_0000, CFG_POOL_BASE,  1'b1, ST_DONE,    32'hFFFF_F000},
        '{ROW_ITEM, OP_ALLOC, 11'd2,    32'h0000_0000, CFG_POOL_BASE,  1'b1, ST_DONE,    32'h0000_1000},
        '{ROW_ITEM, OP_FREE,  11'd1,    32'h0000_1000, CFG_POOL_BASE,  1'b1, ST_RANGE,   32'h0},
        '{ROW_ITEM, OP_ALLOC, 11'd9,    32'h0000_0000, CFG_POOL_BASE,  1'b1, ST_NOSPACE, 32'h0},
        '{ROW_CFG,  OP_ALLOC, 11'd0,    32'd2,         CFG_POOL_COUNT, 1'b0, ST_DONE,    32'h0},
        '{ROW_ITEM, OP_ALLOC, 11'd1,    32'h0000_0000, CFG_POOL_BASE,  1'b0, ST_DONE,    32'h0},
        '{ROW_ITEM, OP_FREE,  11'd2,    32'hFFFF_F000, CFG_POOL_BASE,  1'b0, ST_DONE,    32'h0},
        '{ROW_CFG,  OP_ALLOC, 11'd0,    32'd0,         CFG_POOL_COUNT, 1'b0, ST_DONE,    32'h0},
        '{ROW_ITEM, OP_ALLOC, 11'd1,    32'h0000_0000, CFG_POOL_BASE,  1'b1, ST_NOSPACE, 32'h0},
        '{ROW_ITEM, OP_FREE,  11'd1,    32'hFFFF_F000, CFG_POOL_BASE,  1'b1, ST_RANGE,   32'h0},
        '{ROW_CFG,  OP_ALLOC, 11'd0,    32'd2047,      CFG_POOL_COUNT, 1'b0, ST_DONE,    32'h0},
        '{ROW_ITEM, OP_ALLOC, 11'd3,    32'h0000_0000, CFG_POOL_BASE,  1'b0, ST_DONE,    32'h0},
        '{ROW_ITEM, OP_FREE,  11'd1024, 32'hFFFF_F000, CFG_POOL_BASE,  1'b0, ST_DONE,    32'h0}
    };

    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    logic [47:0]       i_s_axis_tdata  = '0;    // page_count[10:0], free_address[42:11]
    logic              i_s_axis_tuser  = 1'b0;  // op
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    logic [31:0]       o_m_axis_tdata;          // granted_address[31:0]
    logic [1:0]        o_m_axis_tuser;          // status[1:0]
    logic              i_cfg_we        = 1'b0;
    logic              i_cfg_idx       = 1'b0;
    logic [CFG_W-1:0]  i_cfg_wdata     = '0;

    // Predictor state: pool registers and the used-page map
    logic [ADDR_W-1:0] pool_base  = '0;
    logic [CNT_W-1:0]  pool_count = POOL_COUNT_RST;
    logic              page_used [PAGES];
    t_grant            grants_due [$];
    t_run              held_runs [$];

    // Typed expectation of the transaction being offered
    logic              req_typed   = 1'b0;
    t_status           req_status  = ST_DONE;
    logic [ADDR_W-1:0] req_granted = '0;

    logic              idle_en = 1'b1;
    int                mismatch_count = 0;
    int                idle_cycles = 0;
    t_grant            want;
    t_status           pred_status;
    logic [ADDR_W-1:0] pred_granted;

    contiguous_page_bitmap_allocator_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    function automatic int pool_pages();
        return (pool_count > CNT_W'(PAGES)) ? PAGES : int'(pool_count);
    endfunction

    // First-fit allocate or range-checked free on the predictor's map
    function automatic void predict_grant(input t_op op, input logic [CNT_W-1:0] pages,
                                          input logic [ADDR_W-1:0] addr,
                                          output t_status status,
                                          output logic [ADDR_W-1:0] granted);
        int n;
        int run;
        int start;
        int pa;
        int pb;
        n       = pool_pages();
        status  = ST_IGNORED;
        granted = '0;
        if (pages == 0) return;
        if (op == OP_ALLOC) begin
            status = ST_NOSPACE;
            if (int'(pages) > n) return;
            run = 0;
            for (int i = 0; i < n; i++) begin
                run = page_used[i] ? 0 : run + 1;
                if (run == int'(pages)) begin
                    start = i + 1 - int'(pages);
                    for (int k = start; k <= i; k++) page_used[k] = 1'b1;
                    status  = ST_DONE;
                    granted = pool_base + (ADDR_W'(start) << PAGE_SHIFT);
                    held_runs.push_back('{granted, pages});
                    return;
                end
            end
        end else begin
            if (addr == 0) return;
            status = ST_RANGE;
            pa = int'(addr >> PAGE_SHIFT);
            pb = int'(pool_base >> PAGE_SHIFT);
            if (pa < pb) return;
            if (pa - pb >= n || int'(pages) > n - (pa - pb)) return;
            for (int k = pa - pb; k < pa - pb + int'(pages); k++) page_used[k] = 1'b0;
            status = ST_DONE;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP) $display("%0t ns mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic push_request(input t_op op, input logic [CNT_W-1:0] pages,
                                input logic [ADDR_W-1:0] addr, input logic typed,
                                input t_status status, input logic [ADDR_W-1:0] granted);
        int gap;
        gap = idle_en ? $urandom_range(0, 10) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {5'b0, addr, pages};
        req_typed   = typed;
        req_status  = status;
        req_granted = granted;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // Drop valid and hold until every result has come back
    task automatic drain_results();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (grants_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        if (idx == CFG_POOL_BASE) pool_base = value;
        else pool_count = value[CNT_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Result side: random stall before each transaction
    initial begin
        int stall;
        forever begin
            stall = idle_en ? $urandom_range(0, 10) : 0;
            @(negedge i_clk);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_axis_tvalid && i_m_axis_tready));
        end
    end

    always @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            predict_grant(t_op'(i_s_axis_tuser), i_s_axis_tdata[10:0],
                          i_s_axis_tdata[42:11], pred_status, pred_granted);
            if (req_typed) grants_due.push_back('{req_status, req_granted});
            else grants_due.push_back('{pred_status, pred_granted});
        end
        if (o_m_axis_tvalid && i_m_axis_tready) begin
            if (grants_due.size() == 0) begin
                report_mismatch($sformatf("result status %0d with no request pending",
                                          o_m_axis_tuser));
            end else begin
                want = grants_due.pop_front();
                if (o_m_axis_tuser !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              o_m_axis_tuser, want.status));
                if (o_m_axis_tdata !== want.granted)
                    report_mismatch($sformatf("granted address %h, want %h",
                                              o_m_axis_tdata, want.granted));
            end
        end
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int                n;
        int                j;
        int                pick;
        int                upper;
        t_run              held;
        t_op               op_v;
        logic [CNT_W-1:0]  pages_v;
        logic [ADDR_W-1:0] addr_v;
        foreach (page_used[i]) page_used[i] = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_DIR; r++) begin
            if (DIRECTED_ROWS[r].kind == ROW_CFG) begin
                drain_results();
                write_reg(DIRECTED_ROWS[r].reg_idx, DIRECTED_ROWS[r].addr);
            end else begin
                push_request(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].pages,
                             DIRECTED_ROWS[r].addr, DIRECTED_ROWS[r].typed,
                             DIRECTED_ROWS[r].status, DIRECTED_ROWS[r].granted);
            end
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain_results();
            case (p)
                0: begin
                    write_reg(CFG_POOL_BASE, 32'h0);
                    write_reg(CFG_POOL_COUNT, 32'd1024);
                end
                1: begin
                    write_reg(CFG_POOL_BASE, $urandom & 32'hFFFF_F000);
                    write_reg(CFG_POOL_COUNT, $urandom_range(16, 200));
                end
                2: begin
                    write_reg(CFG_POOL_BASE, $urandom);
                    write_reg(CFG_POOL_COUNT, 32'd2047);
                end
                3: begin
                    write_reg(CFG_POOL_BASE, 32'hFFFF_FFFF);
                    write_reg(CFG_POOL_COUNT, 32'd1024);
                end
                default: begin
                    write_reg(CFG_POOL_BASE, $urandom & 32'hFFFF_F000);
                    write_reg(CFG_POOL_COUNT, $urandom_range(1, 48));
                end
            endcase
            // one phase runs with no gaps on either side
            idle_en = (p != 2);
            held_runs.delete();
            n = pool_pages();
            if (n > 0)
                push_request(OP_FREE, CNT_W'(n), (pool_base == 0) ? 32'd1 : pool_base,
                             1'b0, ST_DONE, '0);

            for (int k = 0; k < RANDOM_ITEMS; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    pick  = $urandom_range(0, 99);
                    upper = (n > 0) ? n : 2047;
                    if (pick < 75) pages_v = CNT_W'($urandom_range(1, 8));
                    else if (pick < 95) pages_v = CNT_W'($urandom_range(9, 64));
                    else pages_v = CNT_W'($urandom_range(1, upper));
                    push_request(OP_ALLOC, pages_v, $urandom, 1'b0, ST_DONE, '0);
                end else if (pick < 80 && held_runs.size() > 0) begin
                    // release a granted run, pointing anywhere inside its first page
                    j    = $urandom_range(0, held_runs.size() - 1);
                    held = held_runs[j];
                    held_runs.delete(j);
                    addr_v = held.addr + $urandom_range(0, 4095 - int'(held.addr[11:0]));
                    if (addr_v == 0) addr_v = 32'd1;
                    push_request(OP_FREE, held.pages, addr_v, 1'b0, ST_DONE, '0);
                end else begin
                    op_v    = t_op'($urandom_range(0, 1));
                    pages_v = ($urandom_range(0, 9) == 0) ? '0 : CNT_W'($urandom_range(0, 2047));
                    if ($urandom_range(0, 1) == 0) begin
                        // partial or overlapping free near the pool
                        addr_v  = pool_base + ($urandom_range(0, 1100) << PAGE_SHIFT)
                                  + $urandom_range(0, 4095);
                        pages_v = CNT_W'($urandom_range(1, 64));
                    end else begin
                        addr_v = ($urandom_range(0, 7) == 0) ? '0 : $urandom;
                    end
                    push_request(op_v, pages_v, addr_v, 1'b0, ST_DONE, '0);
                end
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (grants_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", grants_due.size()));
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
